// ===== rtl/kmds_pkg.sv =====
// key matrix debounce scanner: shared constants and types
// no dependencies; used by every other file of the block
package kmds_pkg;

	localparam int ROWS   = 3;
	localparam int COLS   = 3;
	localparam int ROW_W  = 2;
	localparam int COL_W  = 2;
	localparam int LVL_W  = 3;
	localparam int TIME_W = 32;
	localparam int DEB_W  = 16;

	localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd10;

	// what the row lanes found for one item, handed to the merge stage
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROWS-1:0]  mask;
		logic [ROWS-1:0]  lvl;
	} kmds_hit_t;

endpackage

// ===== rtl/kmds_in_if.sv =====
// input channel: one matrix column reading per item
// depends on kmds_pkg
interface kmds_in_if;
	logic                         valid;
	logic                         ready;
	logic [kmds_pkg::COL_W-1:0]  column;
	logic [kmds_pkg::LVL_W-1:0]  row_levels;
	logic [kmds_pkg::TIME_W-1:0] now_ms;

	modport source (output valid, column, row_levels, now_ms, input ready);
	modport sink   (input valid, column, row_levels, now_ms, output ready);
endinterface

// ===== rtl/kmds_out_if.sv =====
// output channel: one key change event per item
// depends on kmds_pkg
interface kmds_out_if;
	logic                        valid;
	logic                        ready;
	logic [kmds_pkg::ROW_W-1:0] event_row;
	logic [kmds_pkg::COL_W-1:0] event_column;
	logic                        pressed;
	logic                        last_event;

	modport source (output valid, event_row, event_column, pressed, last_event, input ready);
	modport sink   (input valid, event_row, event_column, pressed, last_event, output ready);
endinterface

// ===== rtl/kmds_cfg_if.sv =====
// configuration write channel for the debounce setting
// depends on kmds_pkg
interface kmds_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [kmds_pkg::DEB_W-1:0] settle_ms;

	modport source (output valid, settle_ms, input ready);
	modport sink   (input valid, settle_ms, output ready);
endinterface

// ===== rtl/key_matrix_debounce_scanner.sv =====
// top level of the key matrix debounce scanner
// depends on kmds_pkg, the three channel interfaces, kmds_lane and kmds_merge
//
// keys carries one reading per item: the driven column, the row levels seen in it
// and the free-running millisecond time. events gives one item per key whose
// debounced level changed: row, column, new level, and last_event on the final
// event of a reading. cfg writes settle_ms; the user must write it only while
// the block is idle, which the block itself does not enforce; it is always ready.
// a reading is registered, then one lane per row compares and updates its key
// when the merge stage takes it; the merge stage sends events one per cycle while
// events is ready, in ascending row order, through an output register, and each
// event passes the input, merge mask and output registers. a reading with several
// events holds the merge stage until its last event is sent, so readings flow at
// one per cycle only while each has at most one event and events is ready; the serial event output sets the rate.
// reset clears all key levels and change times and sets settle_ms to 10.
// when events stalls, the output register holds, the merge stage fills and
// keys.ready drops after at most one more reading is buffered.
module key_matrix_debounce_scanner (
	input  logic      clk,
	input  logic      arst_n,
	kmds_in_if.sink   keys,
	kmds_out_if.source events,
	kmds_cfg_if.sink  cfg
);

	logic [kmds_pkg::DEB_W-1:0]  debounce_q;
	logic                         valid_s1;
	logic [kmds_pkg::COL_W-1:0]  col_s1;
	logic [kmds_pkg::LVL_W-1:0]  lvl_s1;
	logic [kmds_pkg::TIME_W-1:0] now_s1;

	logic [kmds_pkg::ROWS-1:0]   lane_hit;
	logic [kmds_pkg::ROWS-1:0]   lane_reading;
	logic                         merge_take;
	logic                         adv_s1;
	kmds_pkg::kmds_hit_t         hit;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= kmds_pkg::DEBOUNCE_RESET;
		end else if (cfg.valid) begin
			debounce_q <= cfg.settle_ms;
		end
	end

	assign adv_s1     = valid_s1 && merge_take;
	assign keys.ready = !valid_s1 || merge_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (keys.ready) begin
			valid_s1 <= keys.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (keys.valid && keys.ready) begin
			col_s1 <= keys.column;
			lvl_s1 <= keys.row_levels;
			now_s1 <= keys.now_ms;
		end
	end

	for (genvar r = 0; r < kmds_pkg::ROWS; r++) begin : g_lane
		// rows beyond the level field read as low
		if (r < kmds_pkg::LVL_W) begin : g_rd
			assign lane_reading[r] = lvl_s1[r];
		end else begin : g_low
			assign lane_reading[r] = 1'b0;
		end

		kmds_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.commit   (adv_s1),
			.col      (col_s1),
			.reading  (lane_reading[r]),
			.now      (now_s1),
			.debounce (debounce_q),
			.hit      (lane_hit[r])
		);
	end

	always_comb begin
		hit.col  = col_s1;
		hit.mask = lane_hit;
		hit.lvl  = lane_reading;
	end

	kmds_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.hit_valid (valid_s1),
		.hit       (hit),
		.take      (merge_take),
		.events    (events)
	);

endmodule

// ===== rtl/kmds_lane.sv =====
// one row lane: stable level and last change time of the keys of one row
// depends on kmds_pkg
module kmds_lane (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         commit,
	input  logic [kmds_pkg::COL_W-1:0]  col,
	input  logic                         reading,
	input  logic [kmds_pkg::TIME_W-1:0] now,
	input  logic [kmds_pkg::DEB_W-1:0]  debounce,
	output logic                         hit
);

	logic                         level_q [kmds_pkg::COLS];
	logic [kmds_pkg::TIME_W-1:0] time_q  [kmds_pkg::COLS];

	logic                         col_ok;
	logic                         cur_level;
	logic [kmds_pkg::TIME_W-1:0] cur_time;
	logic [kmds_pkg::TIME_W-1:0] elapsed;

	always_comb begin
		col_ok    = (32'(col) < 32'(kmds_pkg::COLS));
		cur_level = 1'b0;
		cur_time  = '0;
		for (int c = 0; c < kmds_pkg::COLS; c++) begin
			if (32'(col) == 32'(c)) begin
				cur_level = level_q[c];
				cur_time  = time_q[c];
			end
		end
		// wraps modulo 2^32
		elapsed = now - cur_time;
		hit = col_ok && (reading != cur_level)
			&& (elapsed > {{(kmds_pkg::TIME_W-kmds_pkg::DEB_W){1'b0}}, debounce});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < kmds_pkg::COLS; c++) begin
				level_q[c] <= 1'b0;
				time_q[c]  <= '0;
			end
		end else if (commit && hit) begin
			for (int c = 0; c < kmds_pkg::COLS; c++) begin
				if (32'(col) == 32'(c)) begin
					level_q[c] <= reading;
					time_q[c]  <= now;
				end
			end
		end
	end

endmodule

// ===== rtl/kmds_merge.sv =====
// merge stage: turns the lane hit mask into events, lowest row first
// depends on kmds_pkg and kmds_out_if
module kmds_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 hit_valid,
	input  kmds_pkg::kmds_hit_t hit,
	output logic                 take,
	kmds_out_if.source           events
);

	logic [kmds_pkg::ROWS-1:0]  mask_q;
	logic [kmds_pkg::ROWS-1:0]  lvl_q;
	logic [kmds_pkg::COL_W-1:0] col_q;
	logic                        out_valid_q;
	logic [kmds_pkg::ROW_W-1:0] out_row_q;
	logic [kmds_pkg::COL_W-1:0] out_col_q;
	logic                        out_pressed_q;
	logic                        out_last_q;

	logic [kmds_pkg::ROW_W-1:0] pick;
	logic [kmds_pkg::ROWS-1:0]  rest;
	logic                        emit;

	always_comb begin
		pick = '0;
		for (int i = kmds_pkg::ROWS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				pick = kmds_pkg::ROW_W'(i);
			end
		end
		// drop the lowest set bit
		rest = mask_q & (mask_q - 1'b1);
		emit = (|mask_q) && (!out_valid_q || events.ready);
		take = (mask_q == '0) || (emit && (rest == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (take) begin
			mask_q <= hit_valid ? hit.mask : '0;
		end else if (emit) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (take && hit_valid) begin
			col_q <= hit.col;
			lvl_q <= hit.lvl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (events.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_row_q     <= pick;
			out_col_q     <= col_q;
			out_pressed_q <= lvl_q[pick];
			out_last_q    <= (rest == '0);
		end
	end

	assign events.valid        = out_valid_q;
	assign events.event_row    = out_row_q;
	assign events.event_column = out_col_q;
	assign events.pressed      = out_pressed_q;
	assign events.last_event   = out_last_q;

endmodule
